[hdl/quaternion_vector_rotate_assert.svh]
// assertion macros for the quaternion vector rotation block
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define QVR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define QVR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/qvr_pkg.sv]
// types, constants and arithmetic helpers for the quaternion vector rotation block
`default_nettype none
package qvr_pkg;
   localparam int QUAT_W     = 16;
   localparam int VEC_W      = 32;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 33;
   localparam int MAG_W      = 32;
   localparam int QUO_W      = 17;
   localparam int ENT_W      = 16;
   localparam int MPROD_W    = ENT_W + VEC_W;
   localparam int ACC_W      = MPROD_W + 2;
   localparam int RND_W      = ACC_W - 14;
   localparam int DIV_STAGES = QUO_W;
   localparam int LANES      = 9;
   localparam logic [LANES-1:0] DIAG_MASK = 9'b100010001;
   localparam logic [QUAT_W-1:0] MIN_NORM_RESET = 16'd16;
   localparam logic signed [QUO_W:0] ONE_Q14 = 18'sd16384;

   typedef struct packed {
      logic             neg;
      logic             lsb;
      logic [SUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                    ok;
      logic [SUM_W-1:0]        s;
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [VEC_W-1:0] vz;
   } ctx_type;

   // one restoring division step, one quotient bit
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [SUM_W-1:0] s,
                                             input logic first);
      div_lane_type       res;
      logic [SUM_W:0]     trial;
      logic [SUM_W:0]     diff;
      res   = lane;
      trial = {lane.rem, first ? lane.lsb : 1'b0};
      diff  = trial - {1'b0, s};
      if (trial >= {1'b0, s}) begin
         res.rem = diff[SUM_W-1:0];
         res.quo = {lane.quo[QUO_W-2:0], 1'b1};
      end else begin
         res.rem = trial[SUM_W-1:0];
         res.quo = {lane.quo[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

   // round half away from zero, drop 14 fraction bits, saturate to 32 bits
   function automatic logic [VEC_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] sum;
      logic [RND_W-1:0] rnd;
      logic [VEC_W-1:0] res;
      mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      sum = mag + ACC_W'(8192);
      rnd = sum[ACC_W-1:14];
      if (acc[ACC_W-1]) begin
         if (rnd > RND_W'(64'h8000_0000)) res = 32'h8000_0000;
         else res = ~rnd[VEC_W-1:0] + 32'd1;
      end else begin
         if (rnd > RND_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
         else res = rnd[VEC_W-1:0];
      end
      return res;
   endfunction
endpackage
`default_nettype wire

[hdl/qvr_req_if.sv]
// request channel: quaternion and vector
`default_nettype none
interface qvr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [qvr_pkg::QUAT_W-1:0]      quat_w;
   logic signed [qvr_pkg::QUAT_W-1:0]      quat_x;
   logic signed [qvr_pkg::QUAT_W-1:0]      quat_y;
   logic signed [qvr_pkg::QUAT_W-1:0]      quat_z;
   logic signed [qvr_pkg::VEC_W-1:0]       vec_x;
   logic signed [qvr_pkg::VEC_W-1:0]       vec_y;
   logic signed [qvr_pkg::VEC_W-1:0]       vec_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                 output ready);
endinterface
`default_nettype wire

[hdl/qvr_rsp_if.sv]
// response channel: rotated vector and quaternion status
`default_nettype none
interface qvr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [qvr_pkg::VEC_W-1:0]  rot_x;
   logic signed [qvr_pkg::VEC_W-1:0]  rot_y;
   logic signed [qvr_pkg::VEC_W-1:0]  rot_z;
   logic                              quat_ok;
   modport source (output valid, rot_x, rot_y, rot_z, quat_ok, input ready);
   modport sink (input valid, rot_x, rot_y, rot_z, quat_ok, output ready);
endinterface
`default_nettype wire

[hdl/quaternion_vector_rotate.sv]
// quaternion vector rotation top level
//
// Rotates a Q16.16 vector by a Q2.14 quaternion that need not be of unit length.
// Fully pipelined: one transaction per clock while the pipe advances; a 17-stage
// bit-per-stage divider normalizes the nine matrix entries. The whole pipe
// advances whenever the response register is empty or being taken. Quaternions
// whose norm does not exceed csr min_quat_norm (reset 16) give quat_ok low and
// a zero vector. Results saturate.
`default_nettype none
`include "quaternion_vector_rotate_assert.svh"
module quaternion_vector_rotate (
   input  wire logic                          clock,
   input  wire logic                          reset,
   qvr_req_if.sink                            req_chan,
   qvr_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [qvr_pkg::QUAT_W-1:0]    csr_wr_data
);
   localparam int NS = qvr_pkg::DIV_STAGES;
   localparam int NL = qvr_pkg::LANES;

   logic adv;
   logic [qvr_pkg::QUAT_W-1:0]   min_ff;
   logic [qvr_pkg::SUM_W-1:0]    lim_ff;

   // input stage
   logic                                   p1_vld_ff;
   logic signed [qvr_pkg::QUAT_W-1:0]      qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [qvr_pkg::VEC_W-1:0]       vx1_ff, vy1_ff, vz1_ff;

   // product stage
   logic                                   p2_vld_ff;
   logic signed [qvr_pkg::PROD_W-1:0]      ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [qvr_pkg::PROD_W-1:0]      xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [qvr_pkg::VEC_W-1:0]       vx2_ff, vy2_ff, vz2_ff;

   // divider pipe
   logic [NS:0]                            dv_vld_ff;
   qvr_pkg::div_lane_type                  dv_ff [0:NS][0:NL-1];
   qvr_pkg::ctx_type                       cx_ff [0:NS];
   qvr_pkg::div_lane_type                  lane_in [0:NL-1];
   qvr_pkg::ctx_type                       cx_in;
   logic signed [qvr_pkg::SUM_W-1:0]       sum_in [0:NL-1];

   // entry, multiply, accumulate stages
   logic                                   en_vld_ff, mu_vld_ff, ac_vld_ff;
   logic                                   en_ok_ff, mu_ok_ff, ac_ok_ff;
   logic signed [qvr_pkg::ENT_W-1:0]       ent_ff [0:NL-1];
   logic signed [qvr_pkg::VEC_W-1:0]       vx3_ff, vy3_ff, vz3_ff;
   logic signed [qvr_pkg::MPROD_W-1:0]     mp_ff [0:NL-1];
   logic signed [qvr_pkg::ACC_W-1:0]       acc_ff [0:2];
   logic signed [qvr_pkg::QUO_W:0]         ent_in [0:NL-1];

   logic                                   out_vld_ff;
   logic signed [qvr_pkg::VEC_W-1:0]       rot_x_ff, rot_y_ff, rot_z_ff;
   logic                                   ok_ff;

   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.rot_x   = rot_x_ff;
   assign rsp_chan.rot_y   = rot_y_ff;
   assign rsp_chan.rot_z   = rot_z_ff;
   assign rsp_chan.quat_ok = ok_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= qvr_pkg::MIN_NORM_RESET;
      end else if (csr_wr_en) begin
         min_ff <= csr_wr_data;
      end
      lim_ff <= qvr_pkg::SUM_W'(min_ff * min_ff);
   end

   // product sums and divider lane setup
   always_comb begin
      sum_in[0] = $signed({1'b0, ww_ff}) + $signed({1'b0, xx_ff});
      sum_in[1] = qvr_pkg::SUM_W'(xy_ff) - qvr_pkg::SUM_W'(wz_ff);
      sum_in[2] = qvr_pkg::SUM_W'(xz_ff) + qvr_pkg::SUM_W'(wy_ff);
      sum_in[3] = qvr_pkg::SUM_W'(xy_ff) + qvr_pkg::SUM_W'(wz_ff);
      sum_in[4] = $signed({1'b0, ww_ff}) + $signed({1'b0, yy_ff});
      sum_in[5] = qvr_pkg::SUM_W'(yz_ff) - qvr_pkg::SUM_W'(wx_ff);
      sum_in[6] = qvr_pkg::SUM_W'(xz_ff) - qvr_pkg::SUM_W'(wy_ff);
      sum_in[7] = qvr_pkg::SUM_W'(yz_ff) + qvr_pkg::SUM_W'(wx_ff);
      sum_in[8] = $signed({1'b0, ww_ff}) + $signed({1'b0, zz_ff});
      for (int l = 0; l < NL; l++) begin
         logic [qvr_pkg::SUM_W-1:0] mag;
         mag = sum_in[l][qvr_pkg::SUM_W-1] ? qvr_pkg::SUM_W'(-sum_in[l])
                                           : qvr_pkg::SUM_W'(sum_in[l]);
         lane_in[l].neg = sum_in[l][qvr_pkg::SUM_W-1];
         lane_in[l].lsb = mag[0];
         lane_in[l].rem = {1'b0, mag[qvr_pkg::SUM_W-1:1]};
         lane_in[l].quo = '0;
      end
      cx_in.s  = {1'b0, ww_ff} + {1'b0, xx_ff} + {1'b0, yy_ff} + {1'b0, zz_ff};
      cx_in.ok = cx_in.s > lim_ff;
      cx_in.vx = vx2_ff;
      cx_in.vy = vy2_ff;
      cx_in.vz = vz2_ff;
   end

   // entry rounding, sign and diagonal offset
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         logic [qvr_pkg::QUO_W:0] qr;
         qr = ({1'b0, dv_ff[NS][l].quo} + (qvr_pkg::QUO_W+1)'(1)) >> 1;
         ent_in[l] = dv_ff[NS][l].neg ? -$signed(qr) : $signed(qr);
         if (qvr_pkg::DIAG_MASK[l]) ent_in[l] = ent_in[l] - qvr_pkg::ONE_Q14;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         dv_vld_ff  <= '0;
         en_vld_ff  <= 1'b0;
         mu_vld_ff  <= 1'b0;
         ac_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff  <= req_chan.valid;
         p2_vld_ff  <= p1_vld_ff;
         dv_vld_ff  <= {dv_vld_ff[NS-1:0], p2_vld_ff};
         en_vld_ff  <= dv_vld_ff[NS];
         mu_vld_ff  <= en_vld_ff;
         ac_vld_ff  <= mu_vld_ff;
         out_vld_ff <= ac_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qw_ff  <= req_chan.quat_w;
         qx_ff  <= req_chan.quat_x;
         qy_ff  <= req_chan.quat_y;
         qz_ff  <= req_chan.quat_z;
         vx1_ff <= req_chan.vec_x;
         vy1_ff <= req_chan.vec_y;
         vz1_ff <= req_chan.vec_z;

         ww_ff  <= qw_ff * qw_ff;
         xx_ff  <= qx_ff * qx_ff;
         yy_ff  <= qy_ff * qy_ff;
         zz_ff  <= qz_ff * qz_ff;
         xy_ff  <= qx_ff * qy_ff;
         xz_ff  <= qx_ff * qz_ff;
         yz_ff  <= qy_ff * qz_ff;
         wx_ff  <= qw_ff * qx_ff;
         wy_ff  <= qw_ff * qy_ff;
         wz_ff  <= qw_ff * qz_ff;
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
         vz2_ff <= vz1_ff;

         cx_ff[0] <= cx_in;
         for (int l = 0; l < NL; l++) begin
            dv_ff[0][l] <= lane_in[l];
         end
         for (int k = 0; k < NS; k++) begin
            cx_ff[k+1] <= cx_ff[k];
            for (int l = 0; l < NL; l++) begin
               dv_ff[k+1][l] <= qvr_pkg::div_step(dv_ff[k][l], cx_ff[k].s, k == 0);
            end
         end

         for (int l = 0; l < NL; l++) begin
            ent_ff[l] <= ent_in[l][qvr_pkg::ENT_W-1:0];
         end
         en_ok_ff <= cx_ff[NS].ok;
         vx3_ff   <= cx_ff[NS].vx;
         vy3_ff   <= cx_ff[NS].vy;
         vz3_ff   <= cx_ff[NS].vz;

         for (int r = 0; r < 3; r++) begin
            mp_ff[3*r]   <= qvr_pkg::MPROD_W'(ent_ff[3*r] * vx3_ff);
            mp_ff[3*r+1] <= qvr_pkg::MPROD_W'(ent_ff[3*r+1] * vy3_ff);
            mp_ff[3*r+2] <= qvr_pkg::MPROD_W'(ent_ff[3*r+2] * vz3_ff);
         end
         mu_ok_ff <= en_ok_ff;

         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= qvr_pkg::ACC_W'(mp_ff[3*r]) + qvr_pkg::ACC_W'(mp_ff[3*r+1])
                       + qvr_pkg::ACC_W'(mp_ff[3*r+2]);
         end
         ac_ok_ff <= mu_ok_ff;

         ok_ff    <= ac_ok_ff;
         rot_x_ff <= ac_ok_ff ? qvr_pkg::round_sat(acc_ff[0]) : '0;
         rot_y_ff <= ac_ok_ff ? qvr_pkg::round_sat(acc_ff[1]) : '0;
         rot_z_ff <= ac_ok_ff ? qvr_pkg::round_sat(acc_ff[2]) : '0;
      end
   end

   `QVR_ASSERT_SAME(a_bad_quat_zero, clock, reset,
      out_vld_ff && !ok_ff, rot_x_ff == '0 && rot_y_ff == '0 && rot_z_ff == '0,
      "rejected quaternion produced a nonzero vector")
   `QVR_ASSERT_NEXT(a_stall_holds_divider, clock, reset,
      !adv, $stable(dv_vld_ff), "divider pipe moved during a stall")
   `QVR_ASSERT_NEXT(a_accept_enters_pipe, clock, reset,
      req_chan.valid && adv, p1_vld_ff, "accepted transaction did not enter the pipe")
endmodule
`default_nettype wire

[verif/quaternion_vector_rotate_tb.sv]
// self-checking testbench for the quaternion vector rotation block
`timescale 1ns / 1ps
module quaternion_vector_rotate_tb;

   typedef struct packed {
      logic signed [qvr_pkg::QUAT_W-1:0] qw;
      logic signed [qvr_pkg::QUAT_W-1:0] qx;
      logic signed [qvr_pkg::QUAT_W-1:0] qy;
      logic signed [qvr_pkg::QUAT_W-1:0] qz;
      logic signed [qvr_pkg::VEC_W-1:0]  vx;
      logic signed [qvr_pkg::VEC_W-1:0]  vy;
      logic signed [qvr_pkg::VEC_W-1:0]  vz;
   } point_type;

   typedef struct packed {
      logic signed [qvr_pkg::VEC_W-1:0] rx;
      logic signed [qvr_pkg::VEC_W-1:0] ry;
      logic signed [qvr_pkg::VEC_W-1:0] rz;
      logic                             ok;
   } rotated_type;

   localparam int PIPE_DEPTH = 24;
   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [qvr_pkg::QUAT_W-1:0] csr_wr_data = '0;

   qvr_req_if req_chan();
   qvr_rsp_if rsp_chan();

   quaternion_vector_rotate dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   point_type   pending_points[$];
   rotated_type expected_rotations[$];
   logic [qvr_pkg::QUAT_W-1:0] norm_floor = qvr_pkg::MIN_NORM_RESET;
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_off = 0;
   bit hold_request = 0;

   // round(n / d) half away from zero
   function automatic longint div_half_away(longint n, longint d);
      longint mag;
      longint q;
      mag = n < 0 ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return n < 0 ? -q : q;
   endfunction

   function automatic rotated_type rotate_point(point_type p,
                                                logic [qvr_pkg::QUAT_W-1:0] floor_norm);
      rotated_type r;
      longint w, x, y, z, s, acc, mag;
      longint v[3];
      longint m[3][3];
      w = p.qw; x = p.qx; y = p.qy; z = p.qz;
      v[0] = p.vx; v[1] = p.vy; v[2] = p.vz;
      r = '0;
      s = w * w + x * x + y * y + z * z;
      if (s <= longint'(floor_norm) * longint'(floor_norm)) return r;
      m[0][0] = div_half_away((w * w + x * x) * 32768, s) - 16384;
      m[0][1] = div_half_away((x * y - w * z) * 32768, s);
      m[0][2] = div_half_away((x * z + w * y) * 32768, s);
      m[1][0] = div_half_away((x * y + w * z) * 32768, s);
      m[1][1] = div_half_away((w * w + y * y) * 32768, s) - 16384;
      m[1][2] = div_half_away((y * z - w * x) * 32768, s);
      m[2][0] = div_half_away((x * z - w * y) * 32768, s);
      m[2][1] = div_half_away((y * z + w * x) * 32768, s);
      m[2][2] = div_half_away((w * w + z * z) * 32768, s) - 16384;
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
         mag = acc < 0 ? -acc : acc;
         mag = (mag + 8192) >>> 14;
         acc = acc < 0 ? -mag : mag;
         if (acc > 64'sd2147483647) acc = 64'sd2147483647;
         if (acc < -64'sd2147483648) acc = -64'sd2147483648;
         if (i == 0) r.rx = acc[31:0];
         else if (i == 1) r.ry = acc[31:0];
         else r.rz = acc[31:0];
      end
      r.ok = 1'b1;
      return r;
   endfunction

   function automatic point_type random_point();
      point_type p;
      int kind;
      kind = $urandom_range(0, 9);
      p.qw = 16'($urandom); p.qx = 16'($urandom);
      p.qy = 16'($urandom); p.qz = 16'($urandom);
      p.vx = $urandom; p.vy = $urandom; p.vz = $urandom;
      if (kind < 2) begin
         p.qw = 16'($signed(5'($urandom))); p.qx = 16'($signed(5'($urandom)));
         p.qy = 16'($signed(5'($urandom))); p.qz = 16'($signed(5'($urandom)));
      end else if (kind < 4) begin
         p.qx = 16'($signed(10'($urandom))); p.qy = 16'($signed(10'($urandom)));
         p.qz = 16'($signed(10'($urandom)));
      end
      if (kind == 5) begin
         p.vx = 32'($signed(20'($urandom))); p.vy = 32'($signed(20'($urandom)));
         p.vz = 32'($signed(20'($urandom)));
      end
      return p;
   endfunction

   task automatic queue_point(point_type p);
      pending_points.push_back(p);
   endtask

   task automatic drain_pipe();
      while (pending_points.size() != 0 || expected_rotations.size() != 0 || req_chan.valid)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_floor(logic [qvr_pkg::QUAT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      norm_floor = value;
      @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         {req_chan.quat_w, req_chan.quat_x, req_chan.quat_y, req_chan.quat_z,
          req_chan.vec_x, req_chan.vec_y, req_chan.vec_z} <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rotations.push_back(rotate_point(pending_points.pop_front(),
                                                      norm_floor));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               req_chan.valid <= 1'b1;
               {req_chan.quat_w, req_chan.quat_x, req_chan.quat_y, req_chan.quat_z,
                req_chan.vec_x, req_chan.vec_y, req_chan.vec_z} <= pending_points[0];
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      rotated_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rotations.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h %h %h %b",
                  rsp_chan.rot_x, rsp_chan.rot_y, rsp_chan.rot_z, rsp_chan.quat_ok);
            end else begin
               want = expected_rotations.pop_front();
               if (rsp_chan.rot_x !== want.rx || rsp_chan.rot_y !== want.ry ||
                   rsp_chan.rot_z !== want.rz || rsp_chan.quat_ok !== want.ok) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %h %h %h %b got %h %h %h %b",
                        want.rx, want.ry, want.rz, want.ok, rsp_chan.rot_x,
                        rsp_chan.rot_y, rsp_chan.rot_z, rsp_chan.quat_ok);
               end
            end
         end
         if (hold_request) begin
            hold_off = 300;
            hold_request = 0;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 15) < 4) ? ($urandom_range(0, 1) == 1) : 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (pending_points.size() != 0 || expected_rotations.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      point_type p;
      logic [qvr_pkg::QUAT_W-1:0] floors[4];
      floors = '{16'd0, 16'd65535, 16'd2000, 16'd16384};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset floor
      p = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd65536, -32'sd65536, 32'sd12345};
      queue_point(p);
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd100, 32'sd200, 32'sd300};
      queue_point(p);
      p = '{16'sd16, 16'sd0, 16'sd0, 16'sd0, 32'sd1, 32'sd1, 32'sd1};
      queue_point(p);
      p = '{16'sd0, 16'sd0, 16'sd0, 16'sd17, 32'sd1000, 32'sd1, 32'sd1};
      queue_point(p);
      p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      queue_point(p);
      p = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            32'sd2147483647, 32'sd2147483647, 32'sd2147483647};
      queue_point(p);
      p = '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0,
            32'sd2147483647, 32'sd2147483647, 32'sh8000_0000};
      queue_point(p);
      p = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sh8000_0000, 32'sd7, -32'sd7};
      queue_point(p);
      p = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 32'sd3, 32'sh8000_0000, 32'sd5};
      queue_point(p);
      p = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, -32'sd1, 32'sd1, -32'sd1};
      queue_point(p);
      p = '{16'sd9, 16'sd9, 16'sd9, 16'sd9, 32'sd65536, 32'sd65536, 32'sd65536};
      queue_point(p);
      drain_pipe();

      // long receiver hold-off while the sender keeps offering
      repeat (200) queue_point(random_point());
      hold_request = 1;
      wait (hold_request == 0);
      drain_pipe();

      foreach (floors[i]) begin
         write_floor(floors[i]);
         repeat (325) queue_point(random_point());
         drain_pipe();
      end

      if (mismatches == 0 && expected_rotations.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
